/* rtl/tmcw_pkg.sv */
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared constants, operation and character codes, and the command and
// status bundles between the console controller and its datapath.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // port field widths
    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COLIN_W  = 7;
    localparam int ROWIN_W  = 5;
    localparam int POS_W    = 11;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    // internal widths
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LIN_LAST   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_0 = ADDR_W'(CELLS - COLUMNS);

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clear;
        logic scroll;
        logic out_load;
    } tmcw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scroll_req;
        logic clear_last;
        logic scroll_last;
    } tmcw_sts_t;

endpackage

/* rtl/tmcw_datapath.sv */
// ----------------------------------------------------------------------------
// tmcw_datapath
// Screen store, cursor registers, clear and scroll sweep counter, fill
// attribute register and the result register.
// ----------------------------------------------------------------------------
module tmcw_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tmcw_pkg::tmcw_cmd_t           cmd,
    output tmcw_pkg::tmcw_sts_t           sts,
    input  logic [tmcw_pkg::OP_W-1:0]     s_operation,
    input  logic [tmcw_pkg::CHAR_W-1:0]   s_char_code,
    input  logic [tmcw_pkg::COLIN_W-1:0]  s_column,
    input  logic [tmcw_pkg::ROWIN_W-1:0]  s_row,
    input  logic                          cfg_wr_en,
    input  logic [tmcw_pkg::ATTR_W-1:0]   cfg_wr_data,
    output logic [tmcw_pkg::POS_W-1:0]    m_cursor_addr,
    output logic [tmcw_pkg::CHAR_W-1:0]   m_cell_char,
    output logic [tmcw_pkg::ATTR_W-1:0]   m_cell_attr
);
    import tmcw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] q_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] lin_reg, lin_next;
    logic [ATTR_W-1:0] fill_attr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              rd_flag_reg;

    logic              col_in, row_in, rd_hit, put_we, scroll_req;
    logic [COL_W-1:0]  col_sat;
    logic [ROW_W-1:0]  row_sat;
    logic [ADDR_W-1:0] lin_set, lin_row_start, put_addr;
    logic [CELL_W-1:0] put_data, blank_cell;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    // saturated position and its linear address
    assign col_in  = int'(s_column) < COLUMNS;
    assign row_in  = int'(s_row) < ROWS;
    assign col_sat = col_in ? COL_W'(s_column) : COL_LAST;
    assign row_sat = row_in ? ROW_W'(s_row) : ROW_LAST;
    assign lin_set = ADDR_W'(row_sat) * ADDR_W'(COLUMNS) + ADDR_W'(col_sat);

    assign lin_row_start = lin_reg - ADDR_W'(col_reg);
    assign blank_cell    = {fill_attr_reg, BLANK_CHAR};

    // operation decode and cursor update
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        lin_next   = lin_reg;
        put_we     = 1'b0;
        put_addr   = lin_reg;
        put_data   = {fill_attr_reg, s_char_code};
        rd_hit     = 1'b0;
        scroll_req = 1'b0;
        unique case (s_operation)
            OP_PUT: begin
                unique case (s_char_code)
                    CODE_CR: begin
                        col_next = '0;
                        lin_next = lin_row_start;
                    end
                    CODE_LF: begin
                        col_next = '0;
                        if (row_reg == ROW_LAST) begin
                            scroll_req = 1'b1;
                            lin_next   = lin_row_start;
                        end else begin
                            row_next = row_reg + 1'b1;
                            lin_next = lin_row_start + ADDR_W'(COLUMNS);
                        end
                    end
                    CODE_BS: begin
                        if (lin_reg != '0) begin
                            lin_next = lin_reg - 1'b1;
                            put_we   = 1'b1;
                            put_addr = lin_reg - 1'b1;
                            put_data = blank_cell;
                            if (col_reg == '0) begin
                                col_next = COL_LAST;
                                row_next = row_reg - 1'b1;
                            end else begin
                                col_next = col_reg - 1'b1;
                            end
                        end
                    end
                    default: begin
                        put_we = 1'b1;
                        if (lin_reg == LIN_LAST) begin
                            scroll_req = 1'b1;
                            lin_next   = LAST_ROW_0;
                            col_next   = '0;
                        end else begin
                            lin_next = lin_reg + 1'b1;
                            if (col_reg == COL_LAST) begin
                                col_next = '0;
                                row_next = row_reg + 1'b1;
                            end else begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                    end
                endcase
            end
            OP_SET: begin
                col_next = col_sat;
                row_next = row_sat;
                lin_next = lin_set;
            end
            OP_READ: begin
                rd_hit = col_in && row_in;
            end
            default: begin
            end
        endcase
    end

    // sweep status
    assign sts.scroll_req  = scroll_req;
    assign sts.clear_last  = cnt_reg == CNT_W'(CELLS - 1);
    assign sts.scroll_last = cnt_reg == CNT_W'(CELLS);

    // store port selection: clear pass, scroll copy, or single access
    always_comb begin
        if (cmd.clear) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg[ADDR_W-1:0];
            mem_wdata = {RESET_ATTR, BLANK_CHAR};
            mem_re    = 1'b0;
            mem_raddr = lin_set;
        end else if (cmd.scroll) begin
            // write lags the read by one cell; bottom row gets blanks
            mem_we    = cnt_reg != '0;
            mem_waddr = ADDR_W'(cnt_reg - 1'b1);
            mem_wdata = (cnt_reg <= CNT_W'(CELLS - COLUMNS)) ? q_reg : blank_cell;
            mem_re    = cnt_reg < CNT_W'(CELLS - COLUMNS);
            mem_raddr = ADDR_W'(cnt_reg + CNT_W'(COLUMNS));
        end else begin
            mem_we    = cmd.accept && put_we && (s_operation == OP_PUT);
            mem_waddr = put_addr;
            mem_wdata = put_data;
            mem_re    = cmd.accept && rd_hit;
            mem_raddr = lin_set;
        end
    end

    // screen store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            q_reg <= mem[mem_raddr];
        end
    end

    // cursor, fill attribute and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            lin_reg       <= '0;
            fill_attr_reg <= RESET_ATTR;
            cnt_reg       <= '0;
            rd_flag_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fill_attr_reg <= cfg_wr_data;
            end
            if (cmd.accept) begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                lin_reg     <= lin_next;
                rd_flag_reg <= rd_hit;
            end
            if (cmd.clear) begin
                cnt_reg <= sts.clear_last ? '0 : cnt_reg + 1'b1;
            end else if (cmd.scroll) begin
                cnt_reg <= sts.scroll_last ? '0 : cnt_reg + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_cursor_addr <= POS_W'(lin_reg);
            m_cell_char   <= rd_flag_reg ? q_reg[CHAR_W-1:0] : '0;
            m_cell_attr   <= rd_flag_reg ? q_reg[CELL_W-1:CHAR_W] : '0;
        end
    end

    // cursor stays on screen and its three forms agree
    a_lin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(lin_reg) < CELLS)
        else $error("cursor beyond last cell");

    a_lin_match: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(lin_reg) == int'(row_reg) * COLUMNS + int'(col_reg))
        else $error("linear cursor disagrees with row and column");

    a_sweep_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clear && cmd.scroll) && !(cmd.accept && (cmd.clear || cmd.scroll)))
        else $error("store sweep overlaps another access");

endmodule

/* rtl/tmcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Sequencer for the console: clear pass after reset, single-item
// execution, scroll sweep and the result handshake.
// ----------------------------------------------------------------------------
module tmcw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  tmcw_pkg::tmcw_sts_t  sts,
    output tmcw_pkg::tmcw_cmd_t  cmd
);
    import tmcw_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCROLL = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg;

    // command decode
    assign s_ready      = state_reg == ST_IDLE;
    assign cmd.accept   = s_valid && s_ready;
    assign cmd.clear    = state_reg == ST_CLEAR;
    assign cmd.scroll   = state_reg == ST_SCROLL;
    assign cmd.out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign m_valid      = m_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (cmd.accept) state_next = sts.scroll_req ? ST_SCROLL : ST_DONE;
            end
            ST_SCROLL: begin
                if (sts.scroll_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (cmd.out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // scroll request takes the sweep path
    a_scroll_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && sts.scroll_req) |=> (state_reg == ST_SCROLL))
        else $error("scroll request did not start the sweep");

    // a result only appears out of the completion state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside completion");

    // one transaction in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> !s_ready)
        else $error("second transaction taken while busy");

endmodule

/* rtl/text_mode_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit
// Text-mode console writer: character-cell screen store with a linear
// cursor; put character, set cursor and read cell operations, with
// scrolling when the cursor runs off the bottom of the screen.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   operation, char_code, column, row
//   m_       out        m_valid / m_ready   cursor_addr, cell_char, cell_attr
//   cfg_     in         cfg_wr_en           cfg_wr_data (fill attribute)
//
// An item is accepted in the idle state; the done state then loads the result
// register; a read cell uses the store's registered read port in between.
// A put that scrolls first runs a scroll sweep: the store copies one cell
// per cycle, then blanks the bottom row.
// After reset a clearing pass over all cells holds s_ready low; fill
// attribute writes are taken throughout.
// A new transaction is taken while a finished result waits on m_ready.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tmcw_pkg::OP_W-1:0]     s_operation,
    input  logic [tmcw_pkg::CHAR_W-1:0]   s_char_code,
    input  logic [tmcw_pkg::COLIN_W-1:0]  s_column,
    input  logic [tmcw_pkg::ROWIN_W-1:0]  s_row,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tmcw_pkg::POS_W-1:0]    m_cursor_addr,
    output logic [tmcw_pkg::CHAR_W-1:0]   m_cell_char,
    output logic [tmcw_pkg::ATTR_W-1:0]   m_cell_attr,
    input  logic                          cfg_wr_en,
    input  logic [tmcw_pkg::ATTR_W-1:0]   cfg_wr_data
);
    import tmcw_pkg::*;

    tmcw_cmd_t cmd;
    tmcw_sts_t sts;

    // sequencer
    tmcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // store, cursor and result
    tmcw_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_operation   (s_operation),
        .s_char_code   (s_char_code),
        .s_column      (s_column),
        .s_row         (s_row),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_cursor_addr (m_cursor_addr),
        .m_cell_char   (m_cell_char),
        .m_cell_attr   (m_cell_attr)
    );

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit testbench
// Runs put character, set cursor and read cell transactions through the
// console writer under random idling on both channels. A screen mirror keeps
// its own copy of the cells, the cursor and the fill attribute, and checks
// each result field by field. Several fill attributes are used, 0 and 255
// among them.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 110;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_addr;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
    } console_report_t;

    // mirror of the screen store, cursor and fill attribute
    class screen_mirror;
        logic [CELL_W-1:0] screen [CELLS];
        logic [POS_W-1:0]  cursor;
        logic [ATTR_W-1:0] fill_attr;
        console_report_t   awaited_reports [$];
        int                mismatches;

        function new();
            foreach (screen[i]) screen[i] = {RESET_ATTR, BLANK_CHAR};
            cursor     = '0;
            fill_attr  = RESET_ATTR;
            mismatches = 0;
        endfunction

        // scroll up one row when the position ran off the end of the screen
        function int unsigned wrap_bottom(int unsigned pos);
            if (pos < CELLS) return pos;
            for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {fill_attr, BLANK_CHAR};
            return pos - COLUMNS;
        endfunction

        // apply one accepted transaction and queue the result it causes
        function void take_command(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                   logic [COLIN_W-1:0] col, logic [ROWIN_W-1:0] row);
            int unsigned     pos;
            int unsigned     c;
            int unsigned     r;
            console_report_t rep;
            pos = 32'(cursor);
            c   = 32'(col);
            r   = 32'(row);
            rep = '0;
            case (op)
                OP_PUT: begin
                    if (ch == CODE_CR) begin
                        pos = pos - pos % COLUMNS;
                    end else if (ch == CODE_LF) begin
                        pos = wrap_bottom(pos + COLUMNS - pos % COLUMNS);
                    end else if (ch == CODE_BS) begin
                        // backspace at the home position does nothing
                        if (pos > 0) begin
                            pos--;
                            screen[pos] = {fill_attr, BLANK_CHAR};
                        end
                    end else begin
                        screen[pos] = {fill_attr, ch};
                        pos = wrap_bottom(pos + 1);
                    end
                    cursor = POS_W'(pos);
                end
                OP_SET: begin
                    // out of range coordinates saturate
                    if (c >= COLUMNS) c = COLUMNS - 1;
                    if (r >= ROWS) r = ROWS - 1;
                    cursor = POS_W'(r * COLUMNS + c);
                end
                OP_READ: begin
                    if (c < COLUMNS && r < ROWS) begin
                        rep.cell_char = screen[r * COLUMNS + c][CHAR_W-1:0];
                        rep.cell_attr = screen[r * COLUMNS + c][CELL_W-1:CHAR_W];
                    end
                end
                default: ;
            endcase
            rep.cursor_addr = cursor;
            awaited_reports.push_back(rep);
        endfunction

        // compare one result transaction with the oldest awaited one
        function void match_report(logic [POS_W-1:0] pos, logic [CHAR_W-1:0] ch,
                                   logic [ATTR_W-1:0] attr);
            console_report_t want;
            if (awaited_reports.size() == 0) begin
                $error("result with nothing outstanding: cursor_addr %0d", pos);
                mismatches++;
                return;
            end
            want = awaited_reports.pop_front();
            if (pos !== want.cursor_addr) begin
                $error("cursor_addr: expected %0d, actual %0d", want.cursor_addr, pos);
                mismatches++;
            end
            if (ch !== want.cell_char) begin
                $error("cell_char: expected 0x%02h, actual 0x%02h", want.cell_char, ch);
                mismatches++;
            end
            if (attr !== want.cell_attr) begin
                $error("cell_attr: expected 0x%02h, actual 0x%02h", want.cell_attr, attr);
                mismatches++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation;
    logic [CHAR_W-1:0]   s_char_code;
    logic [COLIN_W-1:0]  s_column;
    logic [ROWIN_W-1:0]  s_row;
    logic                m_valid;
    logic                m_ready;
    logic [POS_W-1:0]    m_cursor_addr;
    logic [CHAR_W-1:0]   m_cell_char;
    logic [ATTR_W-1:0]   m_cell_attr;
    logic                cfg_wr_en;
    logic [ATTR_W-1:0]   cfg_wr_data;

    screen_mirror board = new();
    bit           idling = 1'b1;

    text_mode_console_writer_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_char_code   (s_char_code),
        .s_column      (s_column),
        .s_row         (s_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cursor_addr (m_cursor_addr),
        .m_cell_char   (m_cell_char),
        .m_cell_attr   (m_cell_attr),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5ns aclk = ~aclk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(bit enabled);
        int k;
        if (!enabled) return 0;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one transaction and wait for it to be taken
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [COLIN_W-1:0] col, input logic [ROWIN_W-1:0] row);
        int gap;
        gap = pick_gap(idling);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_char_code <= ch;
        s_column    <= col;
        s_row       <= row;
        do @(posedge aclk); while (!s_ready);
        board.take_command(op, ch, col, row);
    endtask

    task automatic write_fill(input logic [ATTR_W-1:0] attr);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= attr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.fill_attr = attr;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.awaited_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // result side stalls
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            stall = pick_gap(idling);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.match_report(m_cursor_addr, m_cell_char, m_cell_attr);
    end

    // stimulus
    initial begin
        logic [ATTR_W-1:0]  phase_attr [5];
        logic [OP_W-1:0]    op;
        logic [CHAR_W-1:0]  ch;
        logic [COLIN_W-1:0] col;
        logic [ROWIN_W-1:0] row;
        int                 k;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_PUT;
        s_char_code = '0;
        s_column    = '0;
        s_row       = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // clearing pass after reset holds s_ready low
        do @(posedge aclk); while (!s_ready);

        // directed: fresh screen, controls, extremes, both scroll causes
        write_fill(8'h1e);
        send_item(OP_READ, 8'h00, 7'd0, 5'd0);
        send_item(OP_PUT, CODE_BS, 7'd0, 5'd0);
        send_item(OP_PUT, 8'h48, 7'd0, 5'd0);
        send_item(OP_PUT, 8'h00, 7'd0, 5'd0);
        send_item(OP_PUT, 8'hff, 7'd0, 5'd0);
        send_item(OP_READ, 8'h00, 7'd0, 5'd0);
        send_item(OP_READ, 8'h00, 7'd2, 5'd0);
        send_item(OP_PUT, CODE_BS, 7'd0, 5'd0);
        send_item(OP_READ, 8'h00, 7'd2, 5'd0);
        send_item(OP_PUT, CODE_CR, 7'd0, 5'd0);
        send_item(OP_PUT, CODE_LF, 7'd0, 5'd0);
        send_item(OP_SET, 8'h00, 7'd127, 5'd31);
        send_item(OP_PUT, 8'h5a, 7'd0, 5'd0);
        send_item(OP_READ, 8'h00, 7'd79, 5'd23);
        send_item(OP_READ, 8'h00, 7'd0, 5'd24);
        send_item(OP_SET, 8'h00, 7'd5, 5'd24);
        send_item(OP_PUT, CODE_LF, 7'd0, 5'd0);
        send_item(OP_READ, 8'h00, 7'd79, 5'd22);
        send_item(OP_READ, 8'h00, 7'd80, 5'd0);
        send_item(OP_READ, 8'h00, 7'd0, 5'd25);
        send_item(OP_READ, 8'hff, 7'd127, 5'd31);
        send_item(OP_UNUSED, 8'hff, 7'd127, 5'd31);
        send_item(OP_SET, 8'h00, 7'd80, 5'd25);
        send_item(OP_SET, 8'h00, 7'd79, 5'd0);
        send_item(OP_SET, 8'h00, 7'd0, 5'd0);
        wait_drained();

        // random phases, one of them without idling
        phase_attr = '{8'h00, 8'hff, 8'($urandom), 8'($urandom), RESET_ATTR};
        for (int ph = 0; ph < 5; ph++) begin
            idling = (ph != 2);
            write_fill(phase_attr[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op  = OP_PUT;
                ch  = 8'($urandom);
                col = 7'($urandom);
                row = 5'($urandom);
                k   = $urandom_range(0, 99);
                if (k < 50) begin
                    // ordinary text, with whatever codes the random byte hits
                end else if (k < 58) begin
                    ch = CODE_CR;
                end else if (k < 64) begin
                    ch = CODE_LF;
                end else if (k < 70) begin
                    ch = CODE_BS;
                end else if (k < 80) begin
                    op = OP_SET;
                    k  = $urandom_range(0, 9);
                    if (k < 7) begin
                        col = COLIN_W'($urandom_range(0, COLUMNS - 1));
                        row = ROWIN_W'($urandom_range(0, ROWS - 1));
                    end else if (k < 9) begin
                        // near the bottom right, so text soon scrolls
                        col = COLIN_W'($urandom_range(COLUMNS - 20, COLUMNS - 1));
                        row = ROWIN_W'(ROWS - 1);
                    end
                end else if (k < 96) begin
                    op = OP_READ;
                    k  = $urandom_range(0, 19);
                    if (k < 10) begin
                        // row under the cursor, where text was just written
                        col = COLIN_W'($urandom_range(0, COLUMNS - 1));
                        row = ROWIN_W'(board.cursor / COLUMNS);
                    end else if (k < 17) begin
                        col = COLIN_W'($urandom_range(0, COLUMNS - 1));
                        row = ROWIN_W'($urandom_range(0, ROWS - 1));
                    end
                end else begin
                    op = OP_UNUSED;
                end
                send_item(op, ch, col, row);
            end
            wait_drained();
        end

        repeat (16) @(posedge aclk);
        if (board.mismatches == 0 && board.awaited_reports.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #60ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
